>>> rtl/aip_pkg.sv
package aip_pkg;

  localparam int unsigned IndexWidth = 16;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned BaseWidth  = 6;
  localparam int unsigned DigitWidth = 7;
  localparam int unsigned QueueDepth = 2;

  localparam logic [BaseWidth-1:0]  RadixReset = 6'd10;
  localparam logic [DigitWidth-1:0] DigitNone  = 7'd64;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7A;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  typedef struct packed {
    logic [7:0] character;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [IndexWidth-1:0] end_index;
    logic                  overflowed;
    logic                  digits_seen;
  } out_word_t;

  // classified byte, as held in the queue
  typedef struct packed {
    logic [DigitWidth-1:0] digit;
    logic                  is_blank;
    logic                  is_plus;
    logic                  is_minus;
    logic                  is_x;
    logic                  last;
  } cls_t;

  // finished string; value is unsigned, negate applied at the port
  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [IndexWidth-1:0] end_index;
    logic                  overflowed;
    logic                  digits_seen;
    logic                  negate;
  } res_t;

  function automatic logic [DigitWidth-1:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CharZero && c <= CharNine) begin
      t = c - CharZero;
      return t[DigitWidth-1:0];
    end
    if (c >= CharUpA && c <= CharUpZ) begin
      t = c - CharUpA + 8'd10;
      return t[DigitWidth-1:0];
    end
    if (c >= CharLowA && c <= CharLowZ) begin
      t = c - CharLowA + 8'd10;
      return t[DigitWidth-1:0];
    end
    return DigitNone;
  endfunction

endpackage

>>> rtl/aip_classify.sv
module aip_classify
  import aip_pkg::*;
(
  input  in_word_t word_i,
  output cls_t     cls_o
);

  assign cls_o.digit    = digit_of(word_i.character);
  // space, and tab through carriage return
  assign cls_o.is_blank = (word_i.character == CharSpace) ||
                          (word_i.character >= CharTab && word_i.character <= CharCr);
  assign cls_o.is_plus  = (word_i.character == CharPlus);
  assign cls_o.is_minus = (word_i.character == CharMinus);
  assign cls_o.is_x     = (word_i.character == CharLowX) || (word_i.character == CharUpX);
  assign cls_o.last     = word_i.last_byte;

endmodule

>>> rtl/aip_queue.sv
module aip_queue
  import aip_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cls_t pop_data_o
);

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  cls_t                mem_q [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] cnt_q;

  assign full_o     = (cnt_q == CntWidth'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/aip_engine.sv
module aip_engine
  import aip_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [BaseWidth-1:0] radix_i,
  input  logic                 q_valid_i,
  input  cls_t                 q_data_i,
  output logic                 q_pop_o,
  output logic                 res_valid_o,
  output res_t                 res_o,
  input  logic                 res_ready_i
);

  localparam logic [1:0] PhSpace  = 2'd0;
  localparam logic [1:0] PhSigned = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  localparam logic [1:0] DsNone = 2'd0;
  localparam logic [1:0] DsSome = 2'd1;
  localparam logic [1:0] DsOver = 2'd2;

  localparam int unsigned ProdWidth = ValueWidth + BaseWidth;

  logic [1:0]            phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic [BaseWidth-1:0]  base_q, base_d;
  logic [ValueWidth-1:0] acc_q, acc_d;
  logic [1:0]            stat_q, stat_d;
  logic                  pend_q, pend_d;
  logic [IndexWidth-1:0] pos_q, pos_d;
  logic [IndexWidth-1:0] stop_q, stop_d;

  logic                  res_valid_q;
  res_t                  res_q, res_d;
  logic                  load;

  logic                  first;
  logic                  do_feed;
  logic [BaseWidth-1:0]  f_base;
  logic [1:0]            f_stat;
  logic [ProdWidth-1:0]  prod;
  logic [ProdWidth:0]    sum;
  logic                  f_stop;
  logic [1:0]            fin_stat;
  logic [IndexWidth-1:0] fin_stop;

  assign q_pop_o = q_valid_i && (!q_data_i.last || !res_valid_q || res_ready_i);
  assign load    = q_pop_o && q_data_i.last;

  assign first = (phase_q == PhSigned) ||
                 (phase_q == PhSpace && !q_data_i.is_blank &&
                  !q_data_i.is_plus && !q_data_i.is_minus);

  // one multiply-accumulate per word
  assign prod   = ProdWidth'(acc_q) * ProdWidth'(f_base);
  assign sum    = {1'b0, prod} + (ProdWidth + 1)'(q_data_i.digit);
  assign f_stop = (f_base == '0) || (q_data_i.digit >= DigitWidth'(f_base));

  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    base_d   = base_q;
    acc_d    = acc_q;
    stat_d   = stat_q;
    pend_d   = pend_q;
    pos_d    = pos_q;
    stop_d   = stop_q;
    do_feed  = 1'b0;
    f_base   = base_q;
    f_stat   = stat_q;
    fin_stat = DsNone;
    fin_stop = '0;
    res_d    = res_q;

    if (q_pop_o) begin
      if (first) begin
        phase_d = PhDigits;
        if ((radix_i == '0 || radix_i == BaseWidth'(16)) && q_data_i.digit == '0) begin
          pend_d = 1'b1;
          base_d = radix_i;
        end else begin
          f_base  = (radix_i == '0) ? BaseWidth'(10) : radix_i;
          do_feed = 1'b1;
        end
      end else if (phase_q == PhSpace && !q_data_i.is_blank) begin
        phase_d = PhSigned;
        neg_d   = q_data_i.is_minus;
      end else if (phase_q == PhDigits) begin
        if (pend_q && q_data_i.is_x) begin
          pend_d = 1'b0;
          base_d = BaseWidth'(16);
        end else if (pend_q) begin
          // held zero becomes an octal or hex digit, then this word is fed
          pend_d  = 1'b0;
          f_base  = (base_q == '0) ? BaseWidth'(8) : base_q;
          f_stat  = DsSome;
          do_feed = 1'b1;
        end else begin
          do_feed = 1'b1;
        end
      end

      if (do_feed) begin
        base_d = f_base;
        stat_d = f_stat;
        if (f_stop) begin
          stop_d  = pos_q;
          phase_d = PhDone;
        end else if (f_stat != DsOver) begin
          if (sum[ProdWidth:ValueWidth] != '0) begin
            stat_d = DsOver;
            acc_d  = '1;
          end else begin
            stat_d = DsSome;
            acc_d  = sum[ValueWidth-1:0];
          end
        end
      end

      if (pos_q != '1) begin
        pos_d = pos_q + 1'b1;
      end

      if (q_data_i.last) begin
        fin_stat = stat_d;
        fin_stop = stop_d;
        if (phase_d == PhDigits) begin
          if (pend_d) begin
            fin_stat = DsSome;
          end
          fin_stop = pos_d;
        end
        res_d.value       = (fin_stat == DsNone) ? '0 : acc_d;
        res_d.end_index   = (fin_stat == DsNone) ? '0 : fin_stop;
        res_d.overflowed  = (fin_stat == DsOver);
        res_d.digits_seen = (fin_stat != DsNone);
        res_d.negate      = (fin_stat == DsSome) && neg_d;

        phase_d = PhSpace;
        neg_d   = 1'b0;
        base_d  = '0;
        acc_d   = '0;
        stat_d  = DsNone;
        pend_d  = 1'b0;
        pos_d   = '0;
        stop_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSpace;
      neg_q       <= 1'b0;
      base_q      <= '0;
      acc_q       <= '0;
      stat_q      <= DsNone;
      pend_q      <= 1'b0;
      pos_q       <= '0;
      stop_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      acc_q   <= acc_d;
      stat_q  <= stat_d;
      pend_q  <= pend_d;
      pos_q   <= pos_d;
      stop_q  <= stop_d;
      if (load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/ascii_integer_parser_unit.sv
// ASCII integer parser, strtoull style.
// Input channel (in_valid_i/in_ready_o/in_word_i): one character per word,
// last_byte set on the final character of a string. Output channel
// (out_valid_o/out_ready_i/out_word_o): one word per string, given for the
// word marked last: value, end_index, overflowed and digits_seen.
// cfg_we_i/cfg_wdata_i write the radix (0 = detect hex, octal or decimal);
// write it only while no string is in flight.
// Throughput: one character per cycle while the output is not stalled,
// limited by the single 64 x 6 bit multiply-accumulate in the parse engine.
// A last character goes into the two-word queue; when the engine pops it,
// after the words queued ahead of it, the result register raises out_valid_o.
// A stalled output holds its word; the engine keeps consuming characters
// until it reaches the next last word, and the queue then fills and drops
// in_ready_o.
// Reset clears the queue, the parse state and out_valid_o, and sets the
// radix to 10.
module ascii_integer_parser_unit
  import aip_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [BaseWidth-1:0] cfg_wdata_i
);

  logic [BaseWidth-1:0] radix_q;
  cls_t                 cls;
  logic                 q_full, q_valid, q_pop;
  cls_t                 q_data;
  res_t                 res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RadixReset;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  aip_classify u_classify (
    .word_i (in_word_i),
    .cls_o  (cls)
  );

  assign in_ready_o = !q_full;

  aip_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !q_full),
    .push_data_i (cls),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  aip_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radix_i     (radix_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .res_valid_o (out_valid_o),
    .res_o       (res),
    .res_ready_i (out_ready_i)
  );

  // two's complement for a minus sign
  assign out_word_o.value       = res.negate ? ('0 - res.value) : res.value;
  assign out_word_o.end_index   = res.end_index;
  assign out_word_o.overflowed  = res.overflowed;
  assign out_word_o.digits_seen = res.digits_seen;

endmodule

>>> tb/sv/tb_ascii_integer_parser_unit.sv
`timescale 1ns / 100ps

module tb_ascii_integer_parser_unit;
  import aip_pkg::*;

  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharVt = 8'h0B;
  localparam logic [7:0] CharFf = 8'h0C;

  localparam logic [BaseWidth-1:0] RadixAuto = 6'd0;
  localparam logic [BaseWidth-1:0] RadixOct  = 6'd8;
  localparam logic [BaseWidth-1:0] RadixDec  = 6'd10;
  localparam logic [BaseWidth-1:0] RadixHex  = 6'd16;

  localparam int unsigned NoDigit = 64;
  localparam int unsigned MaxLetterBase = 36;

  localparam logic [ValueWidth-1:0] AllOnes  = '1;
  localparam logic [IndexWidth-1:0] IndexMax = '1;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseBytes   = 117;
  localparam int unsigned CycleLimit   = 200000;

  typedef enum logic [1:0] {
    SCAN_BLANK,
    SCAN_SIGNED,
    SCAN_DIGITS,
    SCAN_DONE
  } scan_phase_e;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_SOME,
    ACC_OVER
  } acc_state_e;

  typedef struct {
    logic [BaseWidth-1:0] radix;
    in_word_t             word;
    bit                   typed;
    out_word_t            number;
  } script_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_word_t             in_word_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_word_t            out_word_o;
  logic                 cfg_we_i;
  logic [BaseWidth-1:0] cfg_wdata_i;

  ascii_integer_parser_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // parser shadow state
  logic [BaseWidth-1:0]  radix_reg;
  scan_phase_e           scan_phase;
  logic                  minus_sign;
  int unsigned           num_base;
  logic [ValueWidth-1:0] acc;
  acc_state_e            acc_state;
  logic                  zero_held;
  logic [IndexWidth-1:0] char_pos;
  logic [IndexWidth-1:0] stop_pos;

  out_word_t   parsed_numbers[$];
  script_row_t script_rows[$];

  int unsigned mismatches   = 0;
  int unsigned numbers_seen = 0;
  int unsigned bytes_sent   = 0;
  bit          calm         = 1'b0;
  bit          draining     = 1'b0;

  function automatic void clear_number();
    scan_phase = SCAN_BLANK;
    minus_sign = 1'b0;
    num_base   = 0;
    acc        = '0;
    acc_state  = ACC_NONE;
    zero_held  = 1'b0;
    char_pos   = '0;
    stop_pos   = '0;
  endfunction

  function automatic int unsigned char_digit(input logic [7:0] c);
    if (c >= CharZero && c <= CharNine) return int'(c) - int'(CharZero);
    if (c >= CharUpA && c <= CharUpZ) return int'(c) - int'(CharUpA) + 10;
    if (c >= CharLowA && c <= CharLowZ) return int'(c) - int'(CharLowA) + 10;
    return NoDigit;
  endfunction

  function automatic void take_digit(input logic [7:0] c, input logic [IndexWidth-1:0] pos);
    int unsigned           d;
    logic [ValueWidth-1:0] cutoff;
    logic [ValueWidth-1:0] cutlim;
    d = char_digit(c);
    if (num_base == 0 || d >= num_base) begin
      stop_pos   = pos;
      scan_phase = SCAN_DONE;
      return;
    end
    if (acc_state == ACC_OVER) return;
    cutoff = AllOnes / 64'(num_base);
    cutlim = AllOnes % 64'(num_base);
    if (acc > cutoff || (acc == cutoff && 64'(d) > cutlim)) begin
      acc_state = ACC_OVER;
      acc       = AllOnes;
    end else begin
      acc_state = ACC_SOME;
      acc       = acc * 64'(num_base) + 64'(d);
    end
  endfunction

  function automatic void open_number(input logic [7:0] c, input logic [IndexWidth-1:0] pos);
    scan_phase = SCAN_DIGITS;
    if ((radix_reg == RadixAuto || radix_reg == RadixHex) && c == CharZero) begin
      zero_held = 1'b1;
      num_base  = radix_reg;
      return;
    end
    num_base = (radix_reg == RadixAuto) ? RadixDec : radix_reg;
    take_digit(c, pos);
  endfunction

  // a held zero that turned out not to start 0x is an ordinary digit
  function automatic void settle_zero();
    zero_held = 1'b0;
    if (num_base == 0) num_base = RadixOct;
    take_digit(CharZero, '0);
  endfunction

  function automatic void parse_char(input in_word_t w);
    logic [7:0]            c;
    logic [IndexWidth-1:0] pos;
    out_word_t             number;
    c   = w.character;
    pos = char_pos;
    case (scan_phase)
      SCAN_BLANK: begin
        if (c == CharSpace || c == CharTab || c == CharLf || c == CharVt ||
            c == CharFf || c == CharCr) begin
        end else if (c == CharMinus) begin
          minus_sign = 1'b1;
          scan_phase = SCAN_SIGNED;
        end else if (c == CharPlus) begin
          scan_phase = SCAN_SIGNED;
        end else begin
          open_number(c, pos);
        end
      end
      SCAN_SIGNED: begin
        open_number(c, pos);
      end
      SCAN_DIGITS: begin
        if (zero_held && (c == CharLowX || c == CharUpX)) begin
          zero_held = 1'b0;
          num_base  = RadixHex;
        end else begin
          if (zero_held) settle_zero();
          take_digit(c, pos);
        end
      end
      default: begin
      end
    endcase
    if (char_pos != IndexMax) char_pos++;
    if (!w.last_byte) return;

    if (scan_phase == SCAN_DIGITS) begin
      if (zero_held) settle_zero();
      if (scan_phase == SCAN_DIGITS) stop_pos = char_pos;
    end
    number.value = acc;
    if (acc_state == ACC_NONE) number.value = '0;
    if (acc_state == ACC_SOME && minus_sign) number.value = -acc;
    number.end_index   = (acc_state != ACC_NONE) ? stop_pos : '0;
    number.overflowed  = (acc_state == ACC_OVER);
    number.digits_seen = (acc_state != ACC_NONE);
    parsed_numbers.push_back(number);
    clear_number();
  endfunction

  function automatic void check_number(input out_word_t got);
    out_word_t want;
    if (parsed_numbers.size() == 0) begin
      $error("unexpected word: value %h end_index %0d", got.value, got.end_index);
      mismatches++;
      return;
    end
    want = parsed_numbers.pop_front();
    if (got.value !== want.value) begin
      $error("value: expected %h, got %h", want.value, got.value);
      mismatches++;
    end
    if (got.end_index !== want.end_index) begin
      $error("end_index: expected %0d, got %0d", want.end_index, got.end_index);
      mismatches++;
    end
    if (got.overflowed !== want.overflowed) begin
      $error("overflowed: expected %b, got %b", want.overflowed, got.overflowed);
      mismatches++;
    end
    if (got.digits_seen !== want.digits_seen) begin
      $error("digits_seen: expected %b, got %b", want.digits_seen, got.digits_seen);
      mismatches++;
    end
  endfunction

  function automatic void put_row(input logic [BaseWidth-1:0] radix, input logic [7:0] c,
                                  input logic last, input bit typed = 1'b0,
                                  input logic [ValueWidth-1:0] value = '0,
                                  input logic [IndexWidth-1:0] end_index = '0,
                                  input logic overflowed = 1'b0,
                                  input logic digits_seen = 1'b0);
    script_row_t row;
    row.radix                = radix;
    row.word.character       = c;
    row.word.last_byte       = last;
    row.typed                = typed;
    row.number.value         = value;
    row.number.end_index     = end_index;
    row.number.overflowed    = overflowed;
    row.number.digits_seen   = digits_seen;
    script_rows.push_back(row);
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned base);
    int unsigned top;
    int unsigned d;
    top = (base > MaxLetterBase) ? MaxLetterBase : base;
    d   = $urandom_range(0, top - 1);
    if (d < 10) return CharZero + 8'(d);
    return ($urandom_range(0, 1) ? CharUpA : CharLowA) + 8'(d - 10);
  endfunction

  task automatic send_word(input logic [7:0] c, input logic last);
    in_word_t w;
    w.character = c;
    w.last_byte = last;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    parse_char(w);
    bytes_sent++;
  endtask

  // only between strings: wait for the last number and let the engine settle
  task automatic set_radix(input logic [BaseWidth-1:0] r);
    draining = 1'b1;
    in_valid_i <= 1'b0;
    while (parsed_numbers.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    radix_reg = r;
    draining  = 1'b0;
  endtask

  task automatic send_string();
    logic [7:0]  text[$];
    int unsigned base;
    int unsigned n;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(0, 5))
          0: text.push_back(CharSpace);
          1: text.push_back(CharTab);
          2: text.push_back(CharLf);
          3: text.push_back(CharVt);
          4: text.push_back(CharFf);
          default: text.push_back(CharCr);
        endcase
      end
      case ($urandom_range(0, 3))
        0: text.push_back(CharMinus);
        1: text.push_back(CharPlus);
        default: begin
        end
      endcase
      base = radix_reg;
      if (base == RadixAuto || base == RadixHex) begin
        case ($urandom_range(0, 2))
          0: begin
            text.push_back(CharZero);
            text.push_back($urandom_range(0, 1) ? CharLowX : CharUpX);
            base = RadixHex;
          end
          1: begin
            if (base == RadixAuto) begin
              text.push_back(CharZero);
              base = RadixOct;
            end
          end
          default: begin
            if (base == RadixAuto) base = RadixDec;
          end
        endcase
      end
      // long runs of digits are what drive the accumulator into overflow
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 70) : $urandom_range(0, 8);
      repeat (n) text.push_back(digit_char(base));
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
    end
    if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
    foreach (text[i]) send_word(text[i], i == text.size() - 1);
  endtask

  initial begin : stimulus
    int unsigned          phase_radix[10];
    int unsigned          phase_start;
    logic [BaseWidth-1:0] r;
    bit                   at_start;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= RadixReset;
    radix_reg = RadixReset;
    clear_number();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put_row(RadixDec, CharZero, 1'b1, 1'b1, '0, 16'd1, 1'b0, 1'b1);
    put_row(RadixDec, CharSpace, 1'b0);
    put_row(RadixDec, CharTab, 1'b0);
    put_row(RadixDec, CharLf, 1'b0);
    put_row(RadixDec, CharVt, 1'b0);
    put_row(RadixDec, CharFf, 1'b0);
    put_row(RadixDec, CharCr, 1'b0);
    put_row(RadixDec, CharMinus, 1'b0);
    put_row(RadixDec, CharZero + 8'd1, 1'b1, 1'b1, AllOnes, 16'd8, 1'b0, 1'b1);
    put_row(RadixDec, CharPlus, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0);
    put_row(RadixDec, 8'hFF, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0);
    put_row(RadixDec, 8'h00, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0);
    put_row(RadixDec, CharZero + 8'd7, 1'b0);
    put_row(RadixDec, CharLowA, 1'b1, 1'b1, 64'd7, 16'd1, 1'b0, 1'b1);
    // bare 0x, then a lone zero at the end of a string
    put_row(RadixAuto, CharZero, 1'b0);
    put_row(RadixAuto, CharLowX, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0);
    put_row(RadixAuto, CharZero, 1'b1, 1'b1, '0, 16'd1, 1'b0, 1'b1);
    put_row(RadixAuto, CharZero, 1'b0);
    put_row(RadixAuto, CharUpX, 1'b0);
    put_row(RadixAuto, CharZero + 8'd1, 1'b0);
    put_row(RadixAuto, CharUpA + 8'd5, 1'b1, 1'b1, 64'd31, 16'd4, 1'b0, 1'b1);
    put_row(RadixAuto, CharZero, 1'b0);
    put_row(RadixAuto, CharZero + 8'd1, 1'b0);
    put_row(RadixAuto, CharZero + 8'd7, 1'b1, 1'b1, 64'd15, 16'd3, 1'b0, 1'b1);
    put_row(6'd36, CharMinus, 1'b0);
    put_row(6'd36, CharLowZ, 1'b0);
    put_row(6'd36, CharUpZ, 1'b1);

    at_start = 1'b1;
    foreach (script_rows[i]) begin
      if (at_start && script_rows[i].radix != radix_reg) set_radix(script_rows[i].radix);
      send_word(script_rows[i].word.character, script_rows[i].word.last_byte);
      if (script_rows[i].typed) begin
        void'(parsed_numbers.pop_back());
        parsed_numbers.push_back(script_rows[i].number);
      end
      at_start = script_rows[i].word.last_byte;
    end

    phase_radix = '{10, 0, 16, 8, 2, 1, 36, 37, 63, 0};
    for (int unsigned p = 0; p < 12; p++) begin
      r = (p < 10) ? BaseWidth'(phase_radix[p]) : BaseWidth'($urandom_range(0, 63));
      set_radix(r);
      if (p == 11) calm = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_string();
    end

    draining = 1'b1;
    in_valid_i <= 1'b0;
    while (parsed_numbers.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin : result_side
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        check_number(out_word_o);
        numbers_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && numbers_seen >= 40 && !draining) begin
        // long back-pressure while strings keep coming: queue fills, input stalls
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
